[rtl/srsw_pkg.sv]
`timescale 1ns / 1ps

package srsw_pkg;

  // Field widths
  localparam int SEQ_W          = 24;
  localparam int TIME_W         = 32;
  localparam int WORD_W         = 32;
  localparam int SEQ_LSB        = 8;
  localparam int WIN_CFG_W      = 7;
  localparam int TOTAL_W        = 24;

  // Configuration port
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 24;
  localparam logic [WIN_CFG_W-1:0] WIN_RESET = 7'd8;

  // Default slot count of the window memory
  localparam int MAX_WINDOW_DEF = 64;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW = 2'd0,
    CFG_TOTAL  = 2'd1,
    CFG_ADAPT  = 2'd2
  } cfg_idx_t;

  // Step strobes for the RTT unit
  typedef struct packed {
    logic est_en;
    logic diff_en;
    logic dev_en;
  } rtt_ctrl_t;

endpackage

[rtl/srsw_rtt.sv]
`timescale 1ns / 1ps

module srsw_rtt import srsw_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  rtt_ctrl_t         ctrl,
  input  logic [TIME_W-1:0] sample,
  output logic [TIME_W-1:0] timeout
);

  logic [TIME_W-1:0] est_r;
  logic [TIME_W-1:0] dev_r;
  logic [TIME_W-1:0] diff_r;
  logic [TIME_W+1:0] tmo_sum;

  // Smoothed estimate and deviation, one step per strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      est_r <= '0;
      dev_r <= '0;
    end else begin
      if (ctrl.est_en) begin
        est_r <= est_r - (est_r >> 3) + (sample >> 3);
      end
      if (ctrl.dev_en) begin
        dev_r <= dev_r - (dev_r >> 2) + (diff_r >> 2);
      end
    end
  end

  // |sample - estimate|, taken after the estimate has moved
  always_ff @(posedge clk) begin
    if (ctrl.diff_en) begin
      diff_r <= (sample >= est_r) ? (sample - est_r) : (est_r - sample);
    end
  end

  // est + 4*dev, saturated
  assign tmo_sum = {2'b00, est_r} + {dev_r, 2'b00};
  assign timeout = (tmo_sum[TIME_W+1:TIME_W] != 2'b00) ? '1 : tmo_sum[TIME_W-1:0];

endmodule

[rtl/selective_repeat_sender_window.sv]
`timescale 1ns / 1ps

// Sender side of a selective-repeat window. Each request is either a send
// (in_req_type 0) or a received acknowledgement (in_req_type 1, sequence number
// in in_ack_word[31:8]); each yields exactly one result on the out_ channel.
// Per-slot acked flags and send timestamps live in one synchronous memory of
// MAX_WINDOW entries with a single read and a single write port, so requests
// are handled one at a time. A send passes through S_SEND and S_FIN; an ack
// outside the window through S_ACK_CHK and S_FIN. A matching ack goes through
// S_ACK_CHK and S_ACK_RD, then S_EST, S_DIFF and S_DEV when adaptive timing
// is on, then S_SLIDE_RD and S_SLIDE_CHK per slot the base slides over and at
// the unacked slot where it stops, then S_FIN, which holds a stalled result.
// The slide reads one slot at a time through the memory read port.
// No clearing pass is needed after reset: only slots already sent are read.
// Users write registers only while no request is in flight; it is not enforced.
module selective_repeat_sender_window import srsw_pkg::*; #(
  parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  // requests
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_req_type,
  input  logic [WORD_W-1:0]     in_ack_word,
  input  logic [TIME_W-1:0]     in_now_time,
  // results
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_send_accepted,
  output logic                  out_ack_matched,
  output logic [SEQ_W-1:0]      out_window_base,
  output logic [SEQ_W-1:0]      out_next_sequence,
  output logic [TIME_W-1:0]     out_timeout_estimate
);

  localparam int SLOT_W = $clog2(MAX_WINDOW);
  localparam int WIN_W  = ($clog2(MAX_WINDOW + 1) > WIN_CFG_W) ?
                          $clog2(MAX_WINDOW + 1) : WIN_CFG_W;
  localparam int ENT_W  = TIME_W + 1;
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(MAX_WINDOW - 1);
  localparam logic [SLOT_W:0]   SLOT_CNT  = (SLOT_W + 1)'(MAX_WINDOW);
  localparam logic [WIN_W-1:0]  WIN_MAX   = WIN_W'(MAX_WINDOW);

  typedef enum logic [9:0] {
    S_IDLE      = 10'b00_0000_0001,
    S_SEND      = 10'b00_0000_0010,
    S_ACK_CHK   = 10'b00_0000_0100,
    S_ACK_RD    = 10'b00_0000_1000,
    S_EST       = 10'b00_0001_0000,
    S_DIFF      = 10'b00_0010_0000,
    S_DEV       = 10'b00_0100_0000,
    S_SLIDE_RD  = 10'b00_1000_0000,
    S_SLIDE_CHK = 10'b01_0000_0000,
    S_FIN       = 10'b10_0000_0000
  } state_t;

  function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
    return (s == SLOT_LAST) ? '0 : s + 1'b1;
  endfunction

  state_t              state_r, state_nxt;
  logic [WIN_CFG_W-1:0] win_cfg_r;
  logic [TOTAL_W-1:0]  total_r;
  logic                adapt_r;

  logic                req_r;
  logic [SEQ_W-1:0]    seq_r;
  logic [TIME_W-1:0]   now_r;

  logic [SEQ_W-1:0]    base_r, base_nxt;
  logic [SEQ_W-1:0]    next_r, next_nxt;
  logic [SLOT_W-1:0]   base_slot_r, base_slot_nxt;
  logic [SLOT_W-1:0]   next_slot_r, next_slot_nxt;
  logic [SLOT_W-1:0]   ack_slot_r, ack_slot_nxt;
  logic                acc_r, acc_nxt;
  logic                match_r, match_nxt;
  logic [TIME_W-1:0]   sample_r;

  // slot memory: {acked, send stamp}
  logic [ENT_W-1:0]    mem [MAX_WINDOW];
  logic [ENT_W-1:0]    rd_data_r;
  logic                mem_we, mem_re;
  logic [SLOT_W-1:0]   mem_wa, mem_ra;
  logic [ENT_W-1:0]    mem_wd;

  logic [WIN_W-1:0]    win;
  logic [SEQ_W:0]      win_limit;
  logic                send_ok;
  logic                ack_hit;
  logic [SLOT_W-1:0]   ack_off;
  logic [SLOT_W:0]     ack_sum;
  logic [SLOT_W-1:0]   ack_slot;

  rtt_ctrl_t           rtt_ctrl;
  logic [TIME_W-1:0]   tmo;
  logic                out_load;
  logic                out_valid_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_cfg_r <= WIN_RESET;
      total_r   <= '0;
      adapt_r   <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_WINDOW: win_cfg_r <= cfg_wdata[WIN_CFG_W-1:0];
        CFG_TOTAL:  total_r   <= cfg_wdata[TOTAL_W-1:0];
        CFG_ADAPT:  adapt_r   <= cfg_wdata[0];
        default:    ;
      endcase
    end
  end

  assign in_stall = (state_r != S_IDLE);

  // Send window check
  assign win       = (WIN_W'(win_cfg_r) > WIN_MAX) ? WIN_MAX : WIN_W'(win_cfg_r);
  assign win_limit = {1'b0, base_r} + (SEQ_W + 1)'(win);
  assign send_ok   = ({1'b0, next_r} < win_limit) && (next_r < total_r);

  // Ack window check and slot of the acked number (offset stays below MAX_WINDOW)
  assign ack_hit  = (seq_r >= base_r) && (seq_r < next_r);
  assign ack_off  = seq_r[SLOT_W-1:0] - base_r[SLOT_W-1:0];
  assign ack_sum  = {1'b0, base_slot_r} + {1'b0, ack_off};
  assign ack_slot = (ack_sum >= SLOT_CNT) ? SLOT_W'(ack_sum - SLOT_CNT)
                                          : ack_sum[SLOT_W-1:0];

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    base_nxt      = base_r;
    next_nxt      = next_r;
    base_slot_nxt = base_slot_r;
    next_slot_nxt = next_slot_r;
    ack_slot_nxt  = ack_slot_r;
    acc_nxt       = acc_r;
    match_nxt     = match_r;
    mem_we        = 1'b0;
    mem_wa        = ack_slot_r;
    mem_wd        = {1'b1, rd_data_r[TIME_W-1:0]};
    mem_re        = 1'b0;
    mem_ra        = base_slot_r;
    rtt_ctrl      = '0;
    out_load      = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = in_req_type ? S_ACK_CHK : S_SEND;
          acc_nxt   = 1'b0;
          match_nxt = 1'b0;
        end
      end
      S_SEND: begin
        if (send_ok) begin
          mem_we        = 1'b1;
          mem_wa        = next_slot_r;
          mem_wd        = {1'b0, now_r};
          next_nxt      = next_r + 1'b1;
          next_slot_nxt = slot_inc(next_slot_r);
          acc_nxt       = 1'b1;
        end
        state_nxt = S_FIN;
      end
      S_ACK_CHK: begin
        if (ack_hit) begin
          match_nxt    = 1'b1;
          mem_re       = 1'b1;
          mem_ra       = ack_slot;
          ack_slot_nxt = ack_slot;
          state_nxt    = S_ACK_RD;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_ACK_RD: begin
        // mark acked, keep the stamp
        mem_we    = 1'b1;
        state_nxt = adapt_r ? S_EST : S_SLIDE_RD;
      end
      S_EST: begin
        rtt_ctrl.est_en = 1'b1;
        state_nxt       = S_DIFF;
      end
      S_DIFF: begin
        rtt_ctrl.diff_en = 1'b1;
        state_nxt        = S_DEV;
      end
      S_DEV: begin
        rtt_ctrl.dev_en = 1'b1;
        state_nxt       = S_SLIDE_RD;
      end
      S_SLIDE_RD: begin
        if (base_r != next_r) begin
          mem_re    = 1'b1;
          state_nxt = S_SLIDE_CHK;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_SLIDE_CHK: begin
        if (rd_data_r[TIME_W]) begin
          base_nxt      = base_r + 1'b1;
          base_slot_nxt = slot_inc(base_slot_r);
          state_nxt     = S_SLIDE_RD;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      base_r      <= '0;
      next_r      <= '0;
      base_slot_r <= '0;
      next_slot_r <= '0;
      acc_r       <= 1'b0;
      match_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      base_r      <= base_nxt;
      next_r      <= next_nxt;
      base_slot_r <= base_slot_nxt;
      next_slot_r <= next_slot_nxt;
      acc_r       <= acc_nxt;
      match_r     <= match_nxt;
    end
  end

  // Request capture and RTT sample
  always_ff @(posedge clk) begin
    ack_slot_r <= ack_slot_nxt;
    if (state_r == S_IDLE && in_valid) begin
      req_r <= in_req_type;
      seq_r <= in_ack_word[WORD_W-1:SEQ_LSB];
      now_r <= in_now_time;
    end
    if (state_r == S_ACK_RD) begin
      sample_r <= now_r - rd_data_r[TIME_W-1:0];
    end
  end

  // Slot memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_ra];
    end
  end

  srsw_rtt u_rtt (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (rtt_ctrl),
    .sample  (sample_r),
    .timeout (tmo)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_send_accepted    <= acc_r & ~req_r;
      out_ack_matched      <= match_r & req_r;
      out_window_base      <= base_r;
      out_next_sequence    <= next_r;
      out_timeout_estimate <= tmo;
    end
  end

  assign out_valid = out_valid_r;

endmodule

[rtl/srsw_checker.sv]
`timescale 1ns / 1ps

module srsw_checker import srsw_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic              out_send_accepted,
  input logic              out_ack_matched,
  input logic [SEQ_W-1:0]  out_window_base,
  input logic [SEQ_W-1:0]  out_next_sequence,
  input logic [TIME_W-1:0] out_timeout_estimate
);

  // One request at a time: the cycle after an accept is stalled
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request accepted while another is in flight");

  // Base never passes next
  a_base_le_next: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_window_base <= out_next_sequence))
    else $error("window base beyond next sequence");

  // A result is a send or an ack, never both
  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_send_accepted && out_ack_matched))
    else $error("send and ack flags both set");

  // A taken send leaves next above zero
  a_send_advances: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_send_accepted) |-> (out_next_sequence != '0))
    else $error("accepted send did not advance next sequence");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_window_base) &&
      $stable(out_next_sequence) && $stable(out_timeout_estimate)))
    else $error("stalled result changed");

endmodule

bind selective_repeat_sender_window srsw_checker u_srsw_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .in_valid             (in_valid),
  .in_stall             (in_stall),
  .out_valid            (out_valid),
  .out_stall            (out_stall),
  .out_send_accepted    (out_send_accepted),
  .out_ack_matched      (out_ack_matched),
  .out_window_base      (out_window_base),
  .out_next_sequence    (out_next_sequence),
  .out_timeout_estimate (out_timeout_estimate)
);

[sim/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import srsw_pkg::*;

  localparam int SLOTS       = MAX_WINDOW_DEF;
  localparam int QUIET_LIMIT = 4000;  // cycles with no request or result moving
  localparam int HOLD_CYCLES = 400;   // long receiver hold-off
  localparam int TAIL_CYCLES = 40;

  // One request as it goes into the block
  typedef struct packed {
    logic              req_type;
    logic [WORD_W-1:0] ack_word;
    logic [TIME_W-1:0] now_time;
  } sr_req_t;

  // One result as it comes out of the block
  typedef struct packed {
    logic              send_accepted;
    logic              ack_matched;
    logic [SEQ_W-1:0]  window_base;
    logic [SEQ_W-1:0]  next_sequence;
    logic [TIME_W-1:0] timeout_estimate;
  } sr_rsp_t;

  // Shadow of the sender window and its registers
  typedef struct {
    logic [WIN_CFG_W-1:0]         win_cfg;
    logic [TOTAL_W-1:0]           total_cfg;
    logic                         adapt_cfg;
    logic [SLOTS-1:0]             acked;
    logic [SLOTS-1:0][TIME_W-1:0] stamp;
    logic [SEQ_W-1:0]             base;
    logic [SEQ_W-1:0]             nxt;
    logic [TIME_W-1:0]            est;
    logic [TIME_W-1:0]            dev;
  } win_state_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  in_req_type = 1'b0;
  logic [WORD_W-1:0]     in_ack_word = '0;
  logic [TIME_W-1:0]     in_now_time = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  out_send_accepted;
  logic                  out_ack_matched;
  logic [SEQ_W-1:0]      out_window_base;
  logic [SEQ_W-1:0]      out_next_sequence;
  logic [TIME_W-1:0]     out_timeout_estimate;

  sr_req_t    pending_reqs[$];
  sr_rsp_t    exp_results[$];
  win_state_t pred_st;   // advanced as the block accepts requests
  win_state_t plan_st;   // advanced as requests are queued, steers the acks

  logic        req_taken = 1'b0;
  int          in_idle_pct = 30;
  int          out_idle_pct = 30;
  int          hold_reqs = 0;
  int          hold_served = 0;
  int          hold_left = 0;
  int          quiet = 0;
  logic [31:0] gen_now;

  int n_items = 0, n_sent = 0, n_refused = 0, n_matched = 0, n_missed = 0;
  int n_saturated = 0, n_checked = 0, n_errors = 0, n_phases = 0;

  selective_repeat_sender_window DUT (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_wr_en            (cfg_wr_en),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_req_type          (in_req_type),
    .in_ack_word          (in_ack_word),
    .in_now_time          (in_now_time),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_send_accepted    (out_send_accepted),
    .out_ack_matched      (out_ack_matched),
    .out_window_base      (out_window_base),
    .out_next_sequence    (out_next_sequence),
    .out_timeout_estimate (out_timeout_estimate)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic win_state_t fresh_state();
    win_state_t st;
    st.win_cfg   = WIN_RESET;
    st.total_cfg = '0;
    st.adapt_cfg = 1'b0;
    st.acked     = '0;
    st.stamp     = '0;
    st.base      = '0;
    st.nxt       = '0;
    st.est       = '0;
    st.dev       = '0;
    return st;
  endfunction

  function automatic void apply_reg(inout win_state_t st, input cfg_idx_t idx,
                                    input logic [CFG_DATA_W-1:0] val);
    case (idx)
      CFG_WINDOW: st.win_cfg   = val[WIN_CFG_W-1:0];
      CFG_TOTAL:  st.total_cfg = val[TOTAL_W-1:0];
      CFG_ADAPT:  st.adapt_cfg = val[0];
      default: ;
    endcase
  endfunction

  function automatic int slot_for(input logic [SEQ_W-1:0] seq);
    return int'(seq % SLOTS);
  endfunction

  // Window bookkeeping for one request; returns the result it produces
  function automatic sr_rsp_t advance_window(inout win_state_t st, input sr_req_t rq);
    sr_rsp_t          rs;
    logic [SEQ_W:0]   win;
    logic [SEQ_W-1:0] seq;
    logic [31:0]      sample;
    logic [31:0]      diff;
    logic [33:0]      tmo;
    int               s;
    rs = '0;
    if (rq.req_type == 1'b0) begin
      // window above the slot count behaves as a full window; the 24-bit total
      // never exceeds the sequence limit, so no cap is needed
      win = (st.win_cfg > SLOTS) ? (SEQ_W+1)'(SLOTS) : (SEQ_W+1)'(st.win_cfg);
      if ({1'b0, st.nxt} < {1'b0, st.base} + win && st.nxt < st.total_cfg) begin
        s = slot_for(st.nxt);
        st.acked[s] = 1'b0;
        st.stamp[s] = rq.now_time;
        st.nxt = st.nxt + 1'b1;
        rs.send_accepted = 1'b1;
      end
    end else begin
      seq = rq.ack_word[31:8];
      if (seq >= st.base && seq < st.nxt) begin
        s = slot_for(seq);
        rs.ack_matched = 1'b1;
        if (st.adapt_cfg) begin
          sample = rq.now_time - st.stamp[s];
          st.est = st.est - (st.est >> 3) + (sample >> 3);
          diff = (sample >= st.est) ? sample - st.est : st.est - sample;
          st.dev = st.dev - (st.dev >> 2) + (diff >> 2);
        end
        st.acked[s] = 1'b1;
        // slide over contiguous acked slots, never past next
        while (st.base < st.nxt && st.acked[slot_for(st.base)])
          st.base = st.base + 1'b1;
      end
    end
    tmo = {2'b00, st.est} + {st.dev, 2'b00};
    rs.window_base      = st.base;
    rs.next_sequence    = st.nxt;
    rs.timeout_estimate = (tmo[33:32] != 2'b00) ? '1 : tmo[31:0];
    return rs;
  endfunction

  task automatic queue_req(input logic kind, input logic [WORD_W-1:0] word,
                           input logic [TIME_W-1:0] now);
    sr_req_t rq;
    rq = '{req_type: kind, ack_word: word, now_time: now};
    pending_reqs.push_back(rq);
    void'(advance_window(plan_st, rq));
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    apply_reg(pred_st, idx, val);
    apply_reg(plan_st, idx, val);
  endtask

  // Upper data bits carry junk that the narrow registers must drop
  task automatic set_regs(input logic [WIN_CFG_W-1:0] win, input logic [TOTAL_W-1:0] total,
                          input logic adapt);
    write_reg(CFG_WINDOW, {17'($urandom), win});
    write_reg(CFG_TOTAL, total);
    write_reg(CFG_ADAPT, {23'($urandom), adapt});
    n_phases++;
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_reqs.size() != 0 || in_valid || exp_results.size() != 0);
  endtask

  // Random traffic: mostly sends and in-window acks, some noise acks
  task automatic fill_random(input int count);
    logic [SEQ_W-1:0]  seq;
    logic [TIME_W-1:0] t;
    int                r;
    int                span;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      gen_now = gen_now + $urandom_range(1, 3000);
      t = ($urandom_range(0, 9) == 0) ? $urandom : gen_now;
      span = int'(plan_st.nxt - plan_st.base);
      if (r < 50) begin
        queue_req(1'b0, $urandom, t);
      end else if (r < 92 && span > 0) begin
        // lean on the base so the window keeps sliding
        if ($urandom_range(0, 2) == 0) seq = plan_st.base;
        else seq = plan_st.base + SEQ_W'($urandom_range(0, span - 1));
        queue_req(1'b1, {seq, 8'($urandom)}, t);
      end else begin
        case ($urandom_range(0, 2))
          0:       seq = SEQ_W'($urandom);
          1:       seq = plan_st.nxt;
          default: seq = plan_st.base - 1'b1;
        endcase
        queue_req(1'b1, {seq, 8'($urandom)}, t);
      end
    end
  endtask

  // Request driver
  always @(negedge clk) begin : req_driver
    sr_req_t rq;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !req_taken) begin
      // stalled: hold the request unchanged
    end else if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= in_idle_pct) begin
      rq = pending_reqs.pop_front();
      in_valid    <= 1'b1;
      in_req_type <= rq.req_type;
      in_ack_word <= rq.ack_word;
      in_now_time <= rq.now_time;
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Result-side stall, with an occasional long hold-off
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_reqs != hold_served) begin
      hold_served <= hold_served + 1;
      hold_left   <= HOLD_CYCLES;
      out_stall   <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < out_idle_pct);
    end
  end

  // Predict on accepted requests, check accepted results, watch for a hang
  always @(posedge clk) begin : req_monitor
    sr_req_t rq;
    sr_rsp_t want;
    sr_rsp_t got;
    req_taken <= rst_n && in_valid && !in_stall;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        rq = '{req_type: in_req_type, ack_word: in_ack_word, now_time: in_now_time};
        want = advance_window(pred_st, rq);
        exp_results.push_back(want);
        n_items++;
        if (!rq.req_type) begin
          if (want.send_accepted) n_sent++;
          else n_refused++;
        end else begin
          if (want.ack_matched) n_matched++;
          else n_missed++;
        end
        if (want.timeout_estimate == '1) n_saturated++;
      end

      if (out_valid && !out_stall) begin
        got = {out_send_accepted, out_ack_matched, out_window_base,
               out_next_sequence, out_timeout_estimate};
        n_checked++;
        if (exp_results.size() == 0) begin
          n_errors++;
          if (n_errors <= 10)
            $display("error %0d: result with nothing expected: acc=%0d match=%0d",
                     n_errors, got.send_accepted, got.ack_matched);
        end else begin
          want = exp_results.pop_front();
          if (got !== want) begin
            n_errors++;
            if (n_errors <= 10) begin
              $display("error %0d: exp acc=%0d match=%0d base=%h next=%h tmo=%h",
                       n_errors, want.send_accepted, want.ack_matched,
                       want.window_base, want.next_sequence, want.timeout_estimate);
              $display("          got acc=%0d match=%0d base=%h next=%h tmo=%h",
                       got.send_accepted, got.ack_matched,
                       got.window_base, got.next_sequence, got.timeout_estimate);
            end
          end
        end
      end

      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("watchdog: nothing moved for %0d cycles, %0d results outstanding",
                 quiet, exp_results.size());
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin : stimulus
    logic [WIN_CFG_W-1:0] win;
    logic [TOTAL_W-1:0]   total;
    logic                 adapt;
    pred_st = fresh_state();
    plan_st = fresh_state();
    gen_now = 32'd4000;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings: total of zero refuses sends, acks with nothing out miss
    queue_req(1'b0, 32'hFFFF_FFFF, 32'h0000_0000);
    queue_req(1'b1, 32'h0000_0000, 32'hFFFF_FFFF);
    queue_req(1'b1, 32'hFFFF_FFFF, 32'd100);
    wait_drained();

    // Window of zero takes nothing
    set_regs(7'd0, 24'hFF_FFFF, 1'b1);
    queue_req(1'b0, 32'h0, 32'd5);
    wait_drained();

    // Window of one: fill, refuse, ack, late duplicate outside the window, refill
    set_regs(7'd1, 24'hFF_FFFF, 1'b1);
    queue_req(1'b0, $urandom, 32'd1000);
    queue_req(1'b0, $urandom, 32'd1100);
    queue_req(1'b1, {24'd0, 8'hFF}, 32'd1800);
    queue_req(1'b1, {24'd0, 8'h00}, 32'd1900);
    queue_req(1'b0, $urandom, 32'd2000);
    wait_drained();

    // Window above the slot count; duplicates inside the window with a
    // wrapped sample drive the timeout into saturation
    set_regs(7'd127, 24'hFF_FFFF, 1'b1);
    queue_req(1'b0, $urandom, 32'd2100);
    queue_req(1'b0, $urandom, 32'd2200);
    queue_req(1'b1, {24'd3, 8'h5A}, 32'd2199);
    queue_req(1'b1, {24'd3, 8'hA5}, 32'd2199);
    queue_req(1'b1, {24'd3, 8'h3C}, 32'd2199);
    queue_req(1'b1, {24'hFF_FFFF, 8'hC3}, 32'd2300);
    queue_req(1'b1, {24'd1, 8'h0F}, 32'd3000);
    queue_req(1'b1, {24'd2, 8'hF0}, 32'd3100);
    wait_drained();

    // Total reached just past next; adaptive timing off
    set_regs(7'd64, 24'd5, 1'b0);
    queue_req(1'b0, $urandom, 32'd3200);
    queue_req(1'b0, $urandom, 32'd3300);
    queue_req(1'b1, {24'd4, 8'h81}, 32'd3900);
    wait_drained();

    for (int p = 0; p < 10; p++) begin
      total = 24'hFF_FFFF;
      adapt = 1'(($urandom));
      case (p)
        0: begin win = 7'd64;  adapt = 1'b1; end
        1: begin win = 7'd1;   adapt = 1'b0; end
        2: begin win = 7'd127; adapt = 1'b1; end
        3: begin win = 7'd64;  adapt = 1'b1; end
        4: begin
          win = 7'($urandom_range(2, 63));
          total = plan_st.nxt + 24'd40;
        end
        5: begin
          win = 7'($urandom_range(8, 64));
          adapt = 1'b1;
          gen_now = 32'hFFFF_F000 + $urandom_range(0, 255);
        end
        6: win = 7'($urandom_range(65, 127));
        default: begin
          win = 7'($urandom_range(1, 64));
          if ($urandom_range(0, 1) == 0) total = plan_st.nxt + 24'($urandom_range(0, 100));
        end
      endcase
      set_regs(win, total, adapt);
      in_idle_pct  = (p == 2 || p == 3) ? 0 : 30;
      out_idle_pct = (p == 2) ? 0 : 30;
      // receiver holds off while the sender keeps offering
      if (p == 3) hold_reqs++;
      fill_random(75);
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("run: %0d requests over %0d register settings, %0d results checked",
             n_items, n_phases, n_checked);
    $display("run: sends %0d taken / %0d refused, acks %0d matched / %0d missed, %0d saturated",
             n_sent, n_refused, n_matched, n_missed, n_saturated);
    if (n_errors == 0 && exp_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
